// ===== src/mlp_pkg.sv =====
`timescale 1ns / 1ps
package mlp_pkg;
  localparam int NFeat = 43;
  localparam int NHid = 64;
  localparam int NCls = 10;
  localparam int W1Depth = NHid * NFeat;
  localparam int W2Depth = NCls * NHid;
  localparam int W1AW = $clog2(W1Depth);
  localparam int W2AW = $clog2(W2Depth);
  localparam int FAW = (NFeat > 1) ? $clog2(NFeat) : 1;
  localparam int HAW = (NHid > 1) ? $clog2(NHid) : 1;
  localparam int CAW = (NCls > 1) ? $clog2(NCls) : 1;
  localparam int QDepth = 4;
  localparam int QAW = 2;

  typedef enum logic [2:0] {
    ActW1   = 3'd0,
    ActB1   = 3'd1,
    ActW2   = 3'd2,
    ActB2   = 3'd3,
    ActFeat = 3'd4,
    ActRun  = 3'd5
  } action_e;

  typedef struct packed {
    logic [2:0]  action;
    logic [5:0]  row;
    logic [5:0]  col;
    logic [15:0] value;
  } req_t;

  typedef enum logic [2:0] {
    StIdle, StL1, StL1Fin, StL2, StL2Fin
  } state_e;
endpackage

// ===== src/mlp_front.sv =====
`timescale 1ns / 1ps
module mlp_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  mlp_pkg::req_t req_i,
  output logic          busy_o,
  output logic          q_valid_o,
  output mlp_pkg::req_t q_data_o,
  input  logic          q_pop_i
);
  import mlp_pkg::*;

  req_t          mem_q [QDepth];
  logic [QAW:0]  cnt_q, cnt_d;
  logic [QAW-1:0] wr_q, rd_q;
  logic          keep, push;

  // drop requests that do nothing
  always_comb begin
    case (req_i.action)
      ActW1:   keep = (32'(req_i.row) < NHid) && (32'(req_i.col) < NFeat);
      ActB1:   keep = 32'(req_i.row) < NHid;
      ActW2:   keep = (32'(req_i.row) < NCls) && (32'(req_i.col) < NHid);
      ActB2:   keep = 32'(req_i.row) < NCls;
      ActFeat: keep = 32'(req_i.col) < NFeat;
      ActRun:  keep = 1'b1;
      default: keep = 1'b0;
    endcase
  end

  assign busy_o    = (cnt_q == (QAW+1)'(QDepth));
  assign push      = start_i && !busy_o && keep;
  assign q_valid_o = (cnt_q != '0);
  assign q_data_o  = mem_q[rd_q];
  assign cnt_d     = cnt_q + (QAW+1)'(push) - (QAW+1)'(q_pop_i && q_valid_o);

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_q] <= req_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      wr_q  <= '0;
      rd_q  <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (push) wr_q <= wr_q + 1'b1;
      if (q_pop_i && q_valid_o) rd_q <= rd_q + 1'b1;
    end
  end
endmodule

// ===== src/mlp_back.sv =====
`timescale 1ns / 1ps
module mlp_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          q_valid_i,
  input  mlp_pkg::req_t q_data_i,
  output logic          q_pop_o,
  output logic          done_o,
  output logic [3:0]    class_index_o,
  output logic signed [15:0] score_o,
  output logic          last_o
);
  import mlp_pkg::*;

  logic [15:0] w1_mem [W1Depth];
  logic [15:0] w2_mem [W2Depth];
  logic [15:0] b1_mem [NHid];
  logic [15:0] b2_mem [NCls];
  logic [15:0] ft_mem [NFeat];
  logic [15:0] hd_mem [NHid];

  state_e st_q, st_d;
  logic [HAW-1:0] h_q, h_d;
  logic [FAW-1:0] f_q, f_d;
  logic [CAW-1:0] c_q, c_d;
  logic [W1AW-1:0] a1_q, a1_d;
  logic [W2AW-1:0] a2_q, a2_d;
  logic           vld_q, vld_d;
  logic           lastk_q, lastk_d;
  logic [15:0]    ra_q, rb_q, acc_q, acc_d, bias_q;
  logic [31:0]    prod_q;
  logic           pv_q, plast_q;
  logic [15:0]    sum1;
  logic           rd_en;
  logic           is_load, run_go;
  logic           out_q;
  logic [CAW-1:0] oc_q;
  logic [15:0]    os_q;
  logic           ol_q;

  // hold loads while a run is walking the stores
  assign is_load = q_valid_i && (q_data_i.action != ActRun) && (st_q == StIdle);
  assign run_go  = q_valid_i && (q_data_i.action == ActRun) && (st_q == StIdle);
  assign q_pop_o = is_load || run_go;

  always_ff @(posedge clk_i) begin
    if (is_load) begin
      case (q_data_i.action)
        ActW1: w1_mem[W1AW'(32'(q_data_i.row) * NFeat + 32'(q_data_i.col))] <= q_data_i.value;
        ActB1: b1_mem[HAW'(q_data_i.row)] <= q_data_i.value;
        ActW2: w2_mem[W2AW'(32'(q_data_i.row) * NHid + 32'(q_data_i.col))] <= q_data_i.value;
        ActB2: b2_mem[CAW'(q_data_i.row)] <= q_data_i.value;
        ActFeat: ft_mem[FAW'(q_data_i.col)] <= q_data_i.value;
        default: ;
      endcase
    end
  end

  // next state
  always_comb begin
    st_d = st_q;
    case (st_q)
      StIdle:  if (run_go) st_d = StL1;
      StL1:    if (32'(h_q) == NHid-1 && 32'(f_q) == NFeat-1) st_d = StL1Fin;
      StL1Fin: if (!pv_q && !vld_q) st_d = StL2;
      StL2:    if (32'(c_q) == NCls-1 && 32'(h_q) == NHid-1) st_d = StL2Fin;
      StL2Fin: if (!pv_q && !vld_q) st_d = StIdle;
      default: st_d = StIdle;
    endcase
  end

  // walk counters
  always_comb begin
    h_d = h_q; f_d = f_q; c_d = c_q; a1_d = a1_q; a2_d = a2_q;
    rd_en = 1'b0; lastk_d = 1'b0;
    case (st_q)
      StIdle: begin
        h_d = '0; f_d = '0; c_d = '0; a1_d = '0; a2_d = '0;
      end
      StL1: begin
        rd_en = 1'b1;
        lastk_d = (32'(f_q) == NFeat-1);
        a1_d = a1_q + 1'b1;
        if (32'(f_q) == NFeat-1) begin
          f_d = '0;
          h_d = (32'(h_q) == NHid-1) ? '0 : h_q + 1'b1;
        end else begin
          f_d = f_q + 1'b1;
        end
      end
      StL2: begin
        rd_en = 1'b1;
        lastk_d = (32'(h_q) == NHid-1);
        a2_d = a2_q + 1'b1;
        if (32'(h_q) == NHid-1) begin
          h_d = '0;
          c_d = c_q + 1'b1;
        end else begin
          h_d = h_q + 1'b1;
        end
      end
      default: ;
    endcase
  end
  assign vld_d = rd_en;

  // read stage, registered memories
  logic [HAW-1:0] rh_q;
  logic [CAW-1:0] rc_q;
  logic           l2_q;
  always_ff @(posedge clk_i) begin
    if (st_q == StL1) begin
      ra_q   <= ft_mem[f_q];
      rb_q   <= w1_mem[a1_q];
      bias_q <= b1_mem[h_q];
    end else begin
      ra_q   <= hd_mem[h_q];
      rb_q   <= w2_mem[a2_q];
      bias_q <= b2_mem[c_q];
    end
    rh_q <= h_q;
    rc_q <= c_q;
    l2_q <= (st_q == StL2);
  end

  // multiply stage
  logic           lk1_q, l2b_q, first_q, first1_q;
  logic [HAW-1:0] rh2_q;
  logic [CAW-1:0] rc2_q;
  logic [15:0]    bias2_q;
  always_ff @(posedge clk_i) begin
    prod_q   <= 32'($signed(ra_q) * $signed(rb_q));
    plast_q  <= lastk_q;
    rh2_q    <= rh_q;
    rc2_q    <= rc_q;
    l2b_q    <= l2_q;
    bias2_q  <= bias_q;
    first1_q <= first_q;
  end

  // accumulate stage: start from zero for layer 1, bias for layer 2
  logic [15:0] base;
  assign base  = first1_q ? (l2b_q ? bias2_q : 16'd0) : acc_q;
  assign sum1  = base + prod_q[23:8];
  assign acc_d = sum1;

  always_ff @(posedge clk_i) begin
    if (pv_q) begin
      acc_q <= acc_d;
      if (plast_q && !l2b_q) begin
        logic [15:0] r;
        r = sum1 + bias2_q;
        hd_mem[rh2_q] <= (r != 16'd0 && !r[15]) ? r : 16'd0;
      end
      if (plast_q && l2b_q) begin
        oc_q <= rc2_q;
        os_q <= sum1;
        ol_q <= (32'(rc2_q) == NCls-1);
      end
    end
  end

  logic fk_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StIdle; h_q <= '0; f_q <= '0; c_q <= '0; a1_q <= '0; a2_q <= '0;
      vld_q <= 1'b0; lastk_q <= 1'b0; pv_q <= 1'b0; out_q <= 1'b0;
      first_q <= 1'b1; fk_q <= 1'b1;
    end else begin
      st_q <= st_d; h_q <= h_d; f_q <= f_d; c_q <= c_d; a1_q <= a1_d; a2_q <= a2_d;
      vld_q <= vld_d; lastk_q <= lastk_d; pv_q <= vld_q;
      // first element of each dot product
      fk_q <= rd_en ? lastk_d : 1'b1;
      first_q <= fk_q;
      out_q <= pv_q && plast_q && l2b_q;
    end
  end

  assign done_o        = out_q;
  assign class_index_o = 4'(oc_q);
  assign score_o       = os_q;
  assign last_o        = ol_q;
endmodule

// ===== src/mlp_two_layer_relu_inference.sv =====
`timescale 1ns / 1ps
// Two-layer fully connected inference, signed Q8.8.
// Request channel: start with action_i, row_i, col_i, value_i is taken
// on a rising edge where start is high and busy is low. Actions 0..4
// write a weight, bias or feature; writes out of range and actions 6, 7
// are dropped. Action 5 runs the network.
// Requests go into a four-entry queue; busy is high only when it is full.
// Load requests retire one a cycle while no run is in progress. A run
// walks every weight once through a single multiply-accumulate pipe,
// and the queue stalls behind it.
// Each score appears on class_index_o, score_o, last_o for one cycle with
// valid_o high, in class order, last_o on the final class. The receiver
// cannot stall; scores are not held.
// Reset clears control only; stores hold nothing defined until written.
module mlp_two_layer_relu_inference (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic [2:0]         action_i,
  input  logic [5:0]         row_i,
  input  logic [5:0]         col_i,
  input  logic signed [15:0] value_i,
  output logic               valid_o,
  output logic [3:0]         class_index_o,
  output logic signed [15:0] score_o,
  output logic               last_o
);
  import mlp_pkg::*;

  req_t req, qd;
  logic qv, qp;

  assign req.action = action_i;
  assign req.row    = row_i;
  assign req.col    = col_i;
  assign req.value  = value_i;

  mlp_front u_front (
    .clk_i, .rst_ni, .start_i(start), .req_i(req), .busy_o(busy),
    .q_valid_o(qv), .q_data_o(qd), .q_pop_i(qp)
  );

  mlp_back u_back (
    .clk_i, .rst_ni, .q_valid_i(qv), .q_data_i(qd), .q_pop_o(qp),
    .done_o(valid_o), .class_index_o, .score_o, .last_o
  );
endmodule
